// ----- rtl/tli3d_pkg.sv -----
// package for the timed 3-d interpolator
// holds the shared axis count, no dependencies
package tli3d_pkg;
  localparam int unsigned NumAxes = 3;
endpackage

// ----- rtl/tli3d_if.sv -----
// valid/ready channel interface with a generic payload
// depends on nothing
interface tli3d_if #(
  parameter int unsigned W = 8
) (
  input logic clk_i
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/tli3d_lane.sv -----
// one axis lane: diff, multiply, pipelined restoring divide, add
// depends on tli3d_pkg
module tli3d_lane #(
  parameter int unsigned CW = 32,
  parameter int unsigned TW = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [CW-1:0] s_i,
  input  logic [CW-1:0] e_i,
  input  logic [TW-1:0] nmag_i,
  input  logic [TW-1:0] dmag_i,
  input  logic          sgn_i,
  input  logic          eq_i,
  output logic [CW-1:0] pos_o
);
  import tli3d_pkg::*;
  localparam int unsigned PW = CW + TW + 1;
  localparam int unsigned NS = PW;
  logic [CW:0]    dif_q;
  logic [CW-1:0]  s0_q, e0_q;
  logic [TW-1:0]  n0_q, d0_q;
  logic           g0_q, q0_q;
  logic [PW-1:0]  num_q [NS+1];
  logic [TW:0]    rem_q [NS+1];
  logic [TW-1:0]  dv_q  [NS+1];
  logic [CW-1:0]  st_q  [NS+1];
  logic [CW-1:0]  en_q  [NS+1];
  logic           sg_q  [NS+1];
  logic           eqp_q [NS+1];
  logic [CW:0]    pmag;
  logic           pneg;
  logic [CW-1:0]  qlo;
  logic [CW-1:0]  pos_d;
  logic [CW-1:0]  pos_q;
  assign pneg = dif_q[CW];
  assign pmag = pneg ? (~dif_q + 1'b1) : dif_q;
  always_ff @(posedge clk_i) begin
    logic [TW:0]   r;
    logic [TW+1:0] tr;
    if (en_i) begin
      dif_q <= {e_i[CW-1], e_i} - {s_i[CW-1], s_i};
      s0_q <= s_i; e0_q <= e_i; n0_q <= nmag_i; d0_q <= dmag_i;
      g0_q <= sgn_i; q0_q <= eq_i;
      num_q[0] <= PW'(pmag) * PW'(n0_q);
      rem_q[0] <= '0; dv_q[0] <= d0_q; st_q[0] <= s0_q; en_q[0] <= e0_q;
      sg_q[0] <= g0_q ^ pneg; eqp_q[0] <= q0_q;
      // one quotient bit per stage, dividend shifted in msb first
      for (int g = 0; g < NS; g++) begin
        r  = {rem_q[g][TW-1:0], num_q[g][PW-1]};
        tr = {1'b0, r} - {2'b00, dv_q[g]};
        rem_q[g+1] <= tr[TW+1] ? r : tr[TW:0];
        num_q[g+1] <= {num_q[g][PW-2:0], ~tr[TW+1]};
        dv_q[g+1] <= dv_q[g]; st_q[g+1] <= st_q[g]; en_q[g+1] <= en_q[g];
        sg_q[g+1] <= sg_q[g]; eqp_q[g+1] <= eqp_q[g];
      end
    end
  end
  assign qlo = num_q[NS][CW-1:0];
  assign pos_d = eqp_q[NS] ? en_q[NS]
               : (st_q[NS] + (sg_q[NS] ? (~qlo + 1'b1) : qlo));
  always_ff @(posedge clk_i) begin
    if (en_i) pos_q <= pos_d;
  end
  assign pos_o = pos_q;
endmodule

// ----- rtl/timed_linear_interpolation_3d.sv -----
// top level of the timed 3-d interpolator: time front end, three lanes, output skid
// depends on tli3d_pkg, tli3d_if, tli3d_lane
// Takes one beat per cycle when the output side keeps up. A beat's result passes
// through registered steps in this order: time differences, axis difference,
// product, one stage per quotient bit of the restoring divider, final add.
// Latency is set by the divider depth. The pipeline advances only when its last
// stage is free or being drained; a two-entry skid fifo holds finished results,
// and input ready follows output ready in the same cycle through the pop term.
// Equal start and end times yield the end point.
module timed_linear_interpolation_3d #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input logic clk_i,
  input logic rst_ni,
  tli3d_if.sink   in_if,
  tli3d_if.source out_if
);
  import tli3d_pkg::*;
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned LAT = CW + TW + 5;
  // input payload: start i,j,k, end i,j,k, time start, now, end (lsb first)
  logic [CW-1:0] st [NumAxes];
  logic [CW-1:0] ep [NumAxes];
  logic [TW-1:0] t0, t1, t2;
  for (genvar a = 0; a < NumAxes; a++) begin : g_unp
    assign st[a] = in_if.data[a*CW +: CW];
    assign ep[a] = in_if.data[(NumAxes+a)*CW +: CW];
  end
  assign t0 = in_if.data[2*NumAxes*CW +: TW];
  assign t1 = in_if.data[2*NumAxes*CW+TW +: TW];
  assign t2 = in_if.data[2*NumAxes*CW+2*TW +: TW];
  // pipeline valid line
  logic [LAT-1:0] vld_q;
  logic           adv;
  logic [CW-1:0]  pos [NumAxes];
  // skid fifo of two entries
  logic [NumAxes*CW-1:0] fb_q [2];
  logic [1:0] cnt_q;
  logic       wp_q, rp_q;
  logic       push, pop;
  // advance when the result landing in the fifo has room
  assign adv = (cnt_q == 2'd0) || (!vld_q[LAT-1]) ||
               ((cnt_q == 2'd1) && !(vld_q[LAT-2] && vld_q[LAT-1])) || pop;
  assign in_if.ready = adv;
  // time front end
  logic [TW-1:0] nm_q, dm_q;
  logic          sg_q, eq_q;
  logic [CW-1:0] s_q [NumAxes];
  logic [CW-1:0] e_q [NumAxes];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      nm_q <= (t1 >= t0) ? (t1 - t0) : (t0 - t1);
      dm_q <= (t2 >= t0) ? (t2 - t0) : (t0 - t2);
      sg_q <= (t1 < t0) ^ (t2 < t0);
      eq_q <= (t2 == t0);
      s_q <= st; e_q <= ep;
    end
  end
  for (genvar a = 0; a < NumAxes; a++) begin : g_lane
    tli3d_lane #(.CW(CW), .TW(TW)) u_lane (
      .clk_i(clk_i), .en_i(adv),
      .s_i(s_q[a]), .e_i(e_q[a]), .nmag_i(nm_q), .dmag_i(dm_q),
      .sgn_i(sg_q), .eq_i(eq_q), .pos_o(pos[a])
    );
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_if.valid};
    end
  end
  // merge lanes into one result word
  logic [NumAxes*CW-1:0] res;
  for (genvar a = 0; a < NumAxes; a++) begin : g_mrg
    assign res[a*CW +: CW] = pos[a];
  end
  assign push = adv && vld_q[LAT-1];
  assign pop  = out_if.valid && out_if.ready;
  assign out_if.valid = (cnt_q != 2'd0);
  assign out_if.data  = fb_q[rp_q];
  always_ff @(posedge clk_i) begin
    if (push) fb_q[wp_q] <= res;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
